>>> design/rpn_pkg.sv
`default_nettype none
package rpn_pkg;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int DW = 64;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_UNDER   = 3'd2;
   localparam logic [2:0] ST_ADD_OVF = 3'd3;
   localparam logic [2:0] ST_SUB_OVF = 3'd4;
   localparam logic [2:0] ST_MUL_OVF = 3'd5;
   localparam logic [2:0] ST_DIV_ERR = 3'd6;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic load;       // capture request fields
      logic rd_b;       // read entry sp-1 into b
      logic rd_a;       // read entry sp-2 into a
      logic rd_top;     // read entry sp-1 into top
      logic push;       // write at sp and increment
      logic pop2;       // sp -= 2
      logic mul_start;
      logic mul_step;
      logic div_start;
      logic div_step;
      logic fin;        // compute result and status
      logic set_under;
      logic set_full;
   } cmd_type;

   typedef struct packed {
      logic is_op;
      logic full;
      logic under;
      logic empty;
      logic step_done;
      logic is_mul;
      logic is_div;
      logic ok;
   } sts_type;
endpackage
`default_nettype wire

>>> design/rpn_stack_checked_alu_unit.sv
`default_nettype none
// RPN evaluator over a 64-bit signed operand stack.
// Input channel req_*: req_type 0 pushes req_push_value, 1 applies
// req_operation (add, sub, mul, div) to the top two entries.
// Result channel rsp_*: one item per request with status, top of stack
// (0 when empty) and depth after the step.
// One item at a time. Push, stack-full and underflow items skip the operand
// reads; add/sub read both operands, and mul and div in addition run the
// 64-step shift-add multiplier or the 64-step restoring divider.
// The next item is taken in the cycle after the result is accepted.
// Stack lives in a single-port-write memory with a registered read.
// Reset clears the stack pointer; the stack is empty afterwards.
// While rsp_valid waits for rsp_ready the block holds the result and
// does not take a new item.
module rpn_stack_checked_alu_unit #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic req_type,
   input  wire logic signed [63:0] req_push_value,
   input  wire logic [1:0] req_operation,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic signed [63:0] rsp_top_value,
   output logic [6:0] rsp_stack_depth
);
   rpn_pkg::cmd_type cmd;
   rpn_pkg::sts_type sts;

   rpn_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   rpn_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .req_type(req_type),
      .req_push_value(req_push_value), .req_operation(req_operation),
      .cmd(cmd), .sts(sts), .rsp_status(rsp_status),
      .rsp_top_value(rsp_top_value), .rsp_stack_depth(rsp_stack_depth)
   );
endmodule
`default_nettype wire

>>> design/rpn_ctrl.sv
`default_nettype none
module rpn_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   input  wire rpn_pkg::sts_type sts,
   output rpn_pkg::cmd_type cmd
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DEC   = 10'b0000000010,
      S_RDB   = 10'b0000000100,
      S_RDA   = 10'b0000001000,
      S_ARI   = 10'b0000010000,
      S_FIN   = 10'b0000100000,
      S_WR    = 10'b0001000000,
      S_TOP   = 10'b0010000000,
      S_TOPW  = 10'b0100000000,
      S_RSP   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (!sts.is_op) begin
               if (sts.full) begin
                  cmd.set_full = 1'b1;
                  state_in = S_TOP;
               end else begin
                  cmd.push = 1'b1;
                  state_in = S_TOP;
               end
            end else if (sts.under) begin
               cmd.set_under = 1'b1;
               state_in = S_TOP;
            end else begin
               cmd.rd_b = 1'b1;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            cmd.rd_a = 1'b1;
            state_in = S_RDA;
         end
         S_RDA: begin
            cmd.pop2 = 1'b1;
            cmd.mul_start = sts.is_mul;
            cmd.div_start = sts.is_div;
            state_in = S_ARI;
         end
         S_ARI: begin
            if (sts.is_mul || sts.is_div) begin
               cmd.mul_step = sts.is_mul;
               cmd.div_step = sts.is_div;
               if (sts.step_done) state_in = S_FIN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            if (sts.ok) cmd.push = 1'b1;
            state_in = S_TOP;
         end
         S_TOP: begin
            cmd.rd_top = 1'b1;
            state_in = S_TOPW;
         end
         S_TOPW: state_in = S_RSP;
         S_RSP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

>>> design/rpn_dp.sv
`default_nettype none
module rpn_dp #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_type,
   input  wire logic signed [63:0] req_push_value,
   input  wire logic [1:0] req_operation,
   input  wire rpn_pkg::cmd_type cmd,
   output rpn_pkg::sts_type sts,
   output logic [2:0] rsp_status,
   output logic signed [63:0] rsp_top_value,
   output logic [6:0] rsp_stack_depth
);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);

   logic [63:0] mem [STACK_DEPTH];
   logic [PW-1:0] sp_ff;
   logic        type_ff;
   logic [63:0] pv_ff;
   logic [1:0]  op_ff;
   logic [63:0] a_ff, b_ff, rd_ff, top_ff;
   logic [63:0] res_ff;
   logic [2:0]  st_ff;
   logic        top_sel_ff;

   // multiply: shift-add over magnitudes, 128-bit product
   logic [127:0] prod_ff;
   logic [63:0]  mcand_ff, mplier_ff;
   // divide: restoring, magnitudes
   logic [63:0]  quo_ff, rem_ff;
   logic [6:0]   cnt_ff;
   logic         neg_ff;

   logic [63:0] ma, mb;
   assign ma = a_ff[63] ? (64'd0 - a_ff) : a_ff;
   assign mb = b_ff[63] ? (64'd0 - b_ff) : b_ff;

   logic [AW-1:0] wr_addr, rd_addr;
   assign wr_addr = sp_ff[AW-1:0];
   always_comb begin
      if (cmd.rd_a) rd_addr = AW'(sp_ff - PW'(2));
      else rd_addr = AW'(sp_ff - PW'(1));
   end

   logic [63:0] res;
   assign res = type_ff ? res_ff : pv_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) mem[wr_addr] <= res;
      rd_ff <= mem[rd_addr];
   end

   logic [64:0] rem_sh;
   logic [64:0] rem_sub;
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign rem_sub = rem_sh - {1'b0, mb};

   // rounding of quotient
   logic [64:0] r2;
   logic        same, up, down;
   logic [63:0] sq, qf;
   logic signed [63:0] sa, sb, sum, dif;
   logic [127:0] sprod;
   logic        add_ovf, sub_ovf, mul_ovf, div_err;
   assign sa = a_ff;
   assign sb = b_ff;
   assign sum = sa + sb;
   assign dif = sa - sb;
   assign add_ovf = (sa[63] == sb[63]) && (sum[63] != sa[63]);
   assign sub_ovf = (sa[63] != sb[63]) && (dif[63] != sa[63]);
   assign sprod = neg_ff ? (128'd0 - prod_ff) : prod_ff;
   assign mul_ovf = (sprod[127:63] != {65{1'b0}}) && (sprod[127:63] != {65{1'b1}});
   assign div_err = (b_ff == 64'd0) || (a_ff == {1'b1, 63'd0} && b_ff == '1);
   assign r2 = {rem_ff, 1'b0};
   assign same = (a_ff[63] == b_ff[63]);
   assign sq = neg_ff ? (64'd0 - quo_ff) : quo_ff;
   // rem magnitude nonzero; sign of r follows a
   assign up = (rem_ff != 64'd0) && same && (r2 >= {1'b0, mb});
   assign down = (rem_ff != 64'd0) && !same && (r2 > {1'b0, mb});
   assign qf = up ? sq + 64'd1 : (down ? sq - 64'd1 : sq);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         pv_ff <= req_push_value;
         op_ff <= req_operation;
         st_ff <= rpn_pkg::ST_OK;
      end
      if (cmd.rd_b) ;
      if (cmd.rd_a) b_ff <= rd_ff;
      if (cmd.pop2) a_ff <= rd_ff;
      if (cmd.set_full) st_ff <= rpn_pkg::ST_FULL;
      if (cmd.set_under) st_ff <= rpn_pkg::ST_UNDER;
      if (cmd.mul_start || cmd.div_start) cnt_ff <= 7'd0;
      if (cmd.mul_start) begin
         prod_ff <= '0;
         mcand_ff <= (rd_ff[63] ? 64'd0 - rd_ff : rd_ff);
         mplier_ff <= (b_ff[63] ? 64'd0 - b_ff : b_ff);
         neg_ff <= rd_ff[63] ^ b_ff[63];
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= (rd_ff[63] ? 64'd0 - rd_ff : rd_ff);
         neg_ff <= rd_ff[63] ^ b_ff[63];
      end
      if (cmd.mul_step) begin
         prod_ff <= {(mplier_ff[0] ? ({1'b0, prod_ff[127:64]} + {1'b0, mcand_ff})
                                   : {1'b0, prod_ff[127:64]}), prod_ff[63:1]};
         mplier_ff <= mplier_ff >> 1;
         cnt_ff <= cnt_ff + 7'd1;
      end
      if (cmd.div_step) begin
         if (!rem_sub[64]) begin
            rem_ff <= rem_sub[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 7'd1;
      end
      if (cmd.fin) begin
         case (op_ff)
            rpn_pkg::OP_ADD: begin
               res_ff <= sum;
               st_ff <= add_ovf ? rpn_pkg::ST_ADD_OVF : rpn_pkg::ST_OK;
            end
            rpn_pkg::OP_SUB: begin
               res_ff <= dif;
               st_ff <= sub_ovf ? rpn_pkg::ST_SUB_OVF : rpn_pkg::ST_OK;
            end
            rpn_pkg::OP_MUL: begin
               res_ff <= sprod[63:0];
               st_ff <= mul_ovf ? rpn_pkg::ST_MUL_OVF : rpn_pkg::ST_OK;
            end
            default: begin
               res_ff <= qf;
               st_ff <= div_err ? rpn_pkg::ST_DIV_ERR : rpn_pkg::ST_OK;
            end
         endcase
      end
      top_sel_ff <= cmd.rd_top;
      if (top_sel_ff) top_ff <= (sp_ff == '0) ? 64'd0 : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) sp_ff <= '0;
      else if (cmd.push) sp_ff <= sp_ff + PW'(1);
      else if (cmd.pop2) sp_ff <= sp_ff - PW'(2);
   end

   always_comb begin
      sts = '0;
      sts.is_op = type_ff;
      sts.full = (sp_ff >= PW'(STACK_DEPTH));
      sts.under = (sp_ff < PW'(2));
      sts.empty = (sp_ff == '0);
      sts.step_done = (cnt_ff == 7'd63);
      sts.is_mul = (op_ff == rpn_pkg::OP_MUL);
      sts.is_div = (op_ff == rpn_pkg::OP_DIV);
      sts.ok = (st_ff == rpn_pkg::ST_OK);
   end

   assign rsp_status = st_ff;
   assign rsp_top_value = top_ff;
   assign rsp_stack_depth = 7'(sp_ff);
endmodule
`default_nettype wire

>>> design/rpn_checker.sv
`default_nettype none
module rpn_sva (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [6:0] rsp_stack_depth
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd6 && rsp_stack_depth <= 7'd64)
      else $error("bad status or depth");
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second item taken");
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("valid after reset");
endmodule

bind rpn_stack_checked_alu_unit rpn_sva u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_stack_depth(rsp_stack_depth)
);
`default_nettype wire

>>> verif/rpn_checker.sv
`timescale 1ns / 100ps
module rpn_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_type,
   input  wire logic signed [63:0] req_push_value,
   input  wire logic [1:0]         req_operation,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [2:0]         rsp_status,
   input  wire logic signed [63:0] rsp_top_value,
   input  wire logic [6:0]         rsp_stack_depth,
   output int                      fail_count,
   output int                      pending_count,
   output int                      status_seen [0:7]
);
   typedef struct packed {
      logic [2:0]         status;
      logic signed [63:0] top;
      logic [6:0]         depth;
   } calc_result_type;

   localparam int DEPTH = rpn_pkg::STACK_DEPTH_DEF;
   localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

   logic signed [63:0] model_stack [0:DEPTH-1];
   int                 model_sp;
   calc_result_type    expected_q [$];

   function automatic logic signed [63:0] rounded_quotient(logic signed [63:0] a,
                                                           logic signed [63:0] b);
      logic signed [63:0] q, r;
      logic [64:0]        r2, bm;
      logic               same;
      q = a / b;
      r = a - q * b;
      if (r != 0) begin
         r2 = (r < 0) ? {1'b0, -r} << 1 : {1'b0, r} << 1;
         bm = (b < 0) ? {1'b0, -b} : {1'b0, b};
         same = (a < 0) == (b < 0);
         if (same && r2 >= bm) q = q + 1;
         else if (!same && r2 > bm) q = q - 1;
      end
      return q;
   endfunction

   function automatic calc_result_type evaluate(logic kind, logic signed [63:0] val,
                                                logic [1:0] op);
      calc_result_type     res;
      logic signed [63:0]  a, b, v;
      logic signed [127:0] wide;
      res.status = rpn_pkg::ST_OK;
      v = 0;
      if (!kind) begin
         if (model_sp >= DEPTH) res.status = rpn_pkg::ST_FULL;
         else begin
            model_stack[model_sp] = val;
            model_sp++;
         end
      end else if (model_sp < 2) begin
         res.status = rpn_pkg::ST_UNDER;
      end else begin
         b = model_stack[model_sp-1];
         a = model_stack[model_sp-2];
         model_sp -= 2;
         case (op)
            rpn_pkg::OP_ADD: begin
               v = a + b;
               if (a[63] == b[63] && v[63] != a[63]) res.status = rpn_pkg::ST_ADD_OVF;
            end
            rpn_pkg::OP_SUB: begin
               v = a - b;
               if (a[63] != b[63] && v[63] != a[63]) res.status = rpn_pkg::ST_SUB_OVF;
            end
            rpn_pkg::OP_MUL: begin
               wide = 128'(a) * 128'(b);
               v = wide[63:0];
               if (wide > 128'(S_MAX) || wide < 128'(S_MIN))
                  res.status = rpn_pkg::ST_MUL_OVF;
            end
            default: begin
               if (b == 0 || (a == S_MIN && b == -1)) res.status = rpn_pkg::ST_DIV_ERR;
               else v = rounded_quotient(a, b);
            end
         endcase
         if (res.status == rpn_pkg::ST_OK) begin
            model_stack[model_sp] = v;
            model_sp++;
         end
      end
      res.top = model_sp ? model_stack[model_sp-1] : 64'sd0;
      res.depth = 7'(model_sp);
      return res;
   endfunction

   always @(posedge clock) begin
      calc_result_type want;
      if (reset) begin
         model_sp = 0;
         fail_count <= 0;
         expected_q.delete();
         pending_count <= 0;
         for (int i = 0; i < 8; i++) status_seen[i] <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(evaluate(req_type, req_push_value, req_operation));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result item at %0t", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               status_seen[want.status] <= status_seen[want.status] + 1;
               if (want.status !== rsp_status || want.top !== rsp_top_value ||
                   want.depth !== rsp_stack_depth) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp st=%0d top=%0d depth=%0d, ",
                               "got st=%0d top=%0d depth=%0d"},
                              want.status, want.top, want.depth,
                              rsp_status, rsp_top_value, rsp_stack_depth);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_q.size();
      end
   end
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;
   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = 1'b0;
   logic signed [63:0] req_push_value = '0;
   logic [1:0]         req_operation = rpn_pkg::OP_ADD;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [63:0] rsp_top_value;
   logic [6:0]         rsp_stack_depth;
   int                 fail_count, pending_count;
   int                 status_seen [0:7];
   int                 idle_cycles = 0;
   int                 items_sent = 0;
   bit                 hold_rsp = 1'b0;

   always #5 clock = ~clock;

   rpn_stack_checked_alu_unit dut (.*);

   rpn_checker u_checker (.*);

   task automatic send_item(logic kind, logic signed [63:0] val, logic [1:0] op);
      req_valid <= 1'b1;
      req_type <= kind;
      req_push_value <= val;
      req_operation <= op;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_gap();
      req_valid <= 1'b0;
      req_type <= 1'($urandom);
      req_push_value <= {$urandom, $urandom};
      req_operation <= 2'($urandom);
   endtask

   function automatic logic signed [63:0] rand_value();
      case ($urandom_range(0, 7))
         0: return S_MAX - $urandom_range(0, 2);
         1: return S_MIN + $urandom_range(0, 2);
         2: return 64'(int'($urandom_range(0, 20)) - 10);
         3: return 64'(int'($urandom));
         4: return {$urandom, $urandom} >>> $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic burst_gap();
      if ($urandom_range(0, 3) == 0) begin
         send_gap();
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else case ((($time / 10) % 400) < 150 ? 0 : 1)
         0: rsp_ready <= 1'b1;
         default: rsp_ready <= ($urandom_range(0, 2) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(1'b1, '0, rpn_pkg::OP_ADD);
      send_item(1'b0, S_MAX, rpn_pkg::OP_DIV);
      send_item(1'b0, 64'sd1, rpn_pkg::OP_MUL);
      send_item(1'b1, '0, rpn_pkg::OP_ADD);
      send_item(1'b0, S_MIN, rpn_pkg::OP_SUB);
      send_item(1'b0, 64'sd1, rpn_pkg::OP_ADD);
      send_item(1'b1, '0, rpn_pkg::OP_SUB);
      send_item(1'b0, S_MIN, rpn_pkg::OP_ADD);
      send_item(1'b0, -64'sd1, rpn_pkg::OP_ADD);
      send_item(1'b1, '0, rpn_pkg::OP_DIV);
      send_item(1'b0, 64'sd7, rpn_pkg::OP_ADD);
      send_item(1'b0, 64'sd0, rpn_pkg::OP_ADD);
      send_item(1'b1, '0, rpn_pkg::OP_DIV);
      send_item(1'b0, -64'sd7, rpn_pkg::OP_ADD);
      send_item(1'b0, 64'sd2, rpn_pkg::OP_ADD);
      send_item(1'b1, '0, rpn_pkg::OP_DIV);
      send_item(1'b0, S_MAX, rpn_pkg::OP_ADD);
      send_item(1'b0, 64'sd2, rpn_pkg::OP_ADD);
      send_item(1'b1, '0, rpn_pkg::OP_MUL);
      send_item(1'b0, 64'sd5, rpn_pkg::OP_ADD);
      send_item(1'b0, -64'sd3, rpn_pkg::OP_ADD);
      send_item(1'b1, '0, rpn_pkg::OP_MUL);
      for (int i = 0; i < 66; i++) send_item(1'b0, rand_value(), 2'($urandom));

      // long receiver stall with the sender still offering
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 5; i++) send_item(1'b1, rand_value(), 2'($urandom));
      join
      send_gap();
      while (pending_count != 0) @(negedge clock);

      while (items_sent < 1150) begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 55)
               send_item(1'b0, rand_value(), 2'($urandom));
            else
               send_item(1'b1, rand_value(), 2'($urandom));
         end
         burst_gap();
         if ($urandom_range(0, 60) == 0)
            for (int i = 0; i < 70; i++) send_item(1'b0, rand_value(), 2'($urandom));
      end
      send_gap();
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("%0d items sent; status counts ok=%0d full=%0d under=%0d", items_sent,
               status_seen[rpn_pkg::ST_OK], status_seen[rpn_pkg::ST_FULL],
               status_seen[rpn_pkg::ST_UNDER]);
      $display("overflow add=%0d sub=%0d mul=%0d, div errors=%0d",
               status_seen[rpn_pkg::ST_ADD_OVF], status_seen[rpn_pkg::ST_SUB_OVF],
               status_seen[rpn_pkg::ST_MUL_OVF], status_seen[rpn_pkg::ST_DIV_ERR]);
      if (fail_count == 0 && pending_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
